FILE: design/rsf_pkg.sv
package rsf_pkg;

    localparam int MAX_WIDTH_DEF = 8192;

    localparam int PIX_W   = 16;
    localparam int LW_W    = 14;
    localparam int TH_W    = 16;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST = LW_W'(2048);
    localparam logic [TH_W-1:0] THRESHOLD_RST  = TH_W'(200);

    // register index = paddr[2]
    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 1'b1;

    // item held between the line-store read and the decision stage
    typedef struct packed {
        logic             emit;
        logic             fend;
        logic             clr_left;
        logic [PIX_W-1:0] below;
    } s1_item_t;

    // signed a - b > t, with t never negative
    function automatic logic exceeds(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [TH_W-1:0]  t);
        logic [PIX_W-1:0] diff;
        diff = a - b;
        return (a > b) && (TH_W'(diff) > t);
    endfunction

endpackage

FILE: design/raster_speckle_filter_core.sv
// Output path: the line store is read at the edge that accepts the item bringing a pixel's
//   below neighbor; compare and select then write the filtered value into the output
//   register that drives m_tdata, which waits while the output is stalled.
// Throughput: one item per cycle while the output is not back-pressured; the line store reads
//   current and right pixels on two ports and writes the new pixel in the same cycle.
// Reset (aresetn low, synchronous): pointers, counts, left pixel and output valid clear,
//   registers return to line_width 2048 and threshold 200; the line store is not cleared.
module raster_speckle_filter_core #(
    parameter int MAX_WIDTH = rsf_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] pixel_value
    input  logic [1:0]                  s_tuser,   // [0] action, [1] frame_start
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [15:0] filtered_value
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsf_pkg::APB_AW-1:0]  paddr,
    input  logic [rsf_pkg::APB_DW-1:0]  pwdata,
    output logic [rsf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import rsf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [LW_W-1:0]  line_width;
    logic [TH_W-1:0]  threshold;
    logic             s1_valid, s1_take;
    s1_item_t         s1_item;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr_cur, mem_raddr_right;
    logic [PIX_W-1:0] mem_wdata, rd_cur, rd_right;

    assign pready = 1'b1;

    rsf_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .prdata     (prdata),
        .line_width (line_width),
        .threshold  (threshold)
    );

    rsf_seq #(.MAX_WIDTH(MAX_WIDTH)) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .action          (s_tuser[0]),
        .pixel_value     (s_tdata),
        .frame_start     (s_tuser[1]),
        .line_width      (line_width),
        .s1_take         (s1_take),
        .s1_valid        (s1_valid),
        .s1_item         (s1_item),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr_cur   (mem_raddr_cur),
        .mem_raddr_right (mem_raddr_right)
    );

    rsf_line_mem #(.DEPTH(MAX_WIDTH)) u_mem (
        .aclk        (aclk),
        .we          (mem_we),
        .waddr       (mem_waddr),
        .wdata       (mem_wdata),
        .re          (mem_we),
        .raddr_cur   (mem_raddr_cur),
        .raddr_right (mem_raddr_right),
        .rdata_cur   (rd_cur),
        .rdata_right (rd_right)
    );

    rsf_decide u_decide (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .threshold      (threshold),
        .s1_valid       (s1_valid),
        .s1_item        (s1_item),
        .cur            (rd_cur),
        .right          (rd_right),
        .s1_take        (s1_take),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .filtered_value (m_tdata),
        .frame_end      (m_tlast)
    );

    // a ready sink never stalls the input side
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid)
        else $error("accepted item did not reach decision stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && !s1_take) |=> (s1_valid && $stable(s1_item)))
        else $error("stalled decision stage lost or changed its item");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s1_valid))
        else $error("pipeline not empty after reset");

endmodule

FILE: design/rsf_cfg.sv
module rsf_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsf_pkg::APB_AW-1:0]  paddr,
    input  logic [rsf_pkg::APB_DW-1:0]  pwdata,
    input  logic                        pready,
    output logic [rsf_pkg::APB_DW-1:0]  prdata,
    output logic [rsf_pkg::LW_W-1:0]    line_width,
    output logic [rsf_pkg::TH_W-1:0]    threshold
);
    import rsf_pkg::*;

    logic [LW_W-1:0]      line_width_reg;
    logic [TH_W-1:0]      threshold_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx   = paddr[2 +: REG_IDX_W];
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RST;
            threshold_reg  <= THRESHOLD_RST;
        end else if (wr_en) begin
            case (idx)
                REG_LINE_WIDTH: line_width_reg <= pwdata[LW_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[TH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LINE_WIDTH: prdata = APB_DW'(line_width_reg);
            REG_THRESHOLD:  prdata = APB_DW'(threshold_reg);
            default:        prdata = '0;
        endcase
    end

    assign line_width = line_width_reg;
    assign threshold  = threshold_reg;

endmodule

FILE: design/rsf_line_mem.sv
module rsf_line_mem #(
    parameter int DEPTH = rsf_pkg::MAX_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [rsf_pkg::PIX_W-1:0]  wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr_cur,
    input  logic [$clog2(DEPTH)-1:0]   raddr_right,
    output logic [rsf_pkg::PIX_W-1:0]  rdata_cur,
    output logic [rsf_pkg::PIX_W-1:0]  rdata_right
);
    import rsf_pkg::*;

    logic [PIX_W-1:0] store_reg [DEPTH];
    logic [PIX_W-1:0] rd_cur_reg;
    logic [PIX_W-1:0] rd_right_reg;

    // read-before-write: a read of the entry written on the same edge gets the old pixel
    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_cur_reg   <= store_reg[raddr_cur];
            rd_right_reg <= store_reg[raddr_right];
        end
    end

    assign rdata_cur   = rd_cur_reg;
    assign rdata_right = rd_right_reg;

endmodule

FILE: design/rsf_seq.sv
module rsf_seq #(
    parameter int MAX_WIDTH = rsf_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          action,
    input  logic [rsf_pkg::PIX_W-1:0]     pixel_value,
    input  logic                          frame_start,
    input  logic [rsf_pkg::LW_W-1:0]      line_width,
    input  logic                          s1_take,
    output logic                          s1_valid,
    output rsf_pkg::s1_item_t             s1_item,
    output logic                          mem_we,
    output logic [$clog2(MAX_WIDTH)-1:0]  mem_waddr,
    output logic [rsf_pkg::PIX_W-1:0]     mem_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0]  mem_raddr_cur,
    output logic [$clog2(MAX_WIDTH)-1:0]  mem_raddr_right
);
    import rsf_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (CW > LW_W) ? CW : LW_W;

    logic [AW-1:0] wp_reg,   wp_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic          s1_valid_reg, s1_valid_next;
    s1_item_t      s1_item_reg;

    logic [CMPW-1:0] lw_ext;
    logic [CW-1:0]   row;
    logic [AW-1:0]   wp_base, wp_eff;
    logic [CW-1:0]   fill_base, fill_eff, pend_base, pend_dec, wp_inc;
    logic [PIX_W-1:0] pix;
    logic            accept, emit, fend;

    assign s_tready = !s1_valid_reg || s1_take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        lw_ext = CMPW'(line_width);
        if (lw_ext < CMPW'(2)) begin
            row = CW'(2);
        end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
            row = CW'(MAX_WIDTH);
        end else begin
            row = CW'(lw_ext);
        end

        wp_base   = frame_start ? '0 : wp_reg;
        fill_base = frame_start ? '0 : fill_reg;
        pend_base = frame_start ? '0 : pend_reg;

        // a shortened row wraps the pointer and saturates the fill count
        wp_eff   = (CW'(wp_base) >= row) ? '0 : wp_base;
        fill_eff = (fill_base > row) ? row : fill_base;

        pix  = action ? '0 : pixel_value;
        emit = (fill_eff == row) && (!action || pend_base != '0);
        pend_dec = (emit && pend_base != '0) ? pend_base - CW'(1) : pend_base;
        fend = emit && action && (pend_dec == '0);

        wp_inc  = CW'(wp_eff) + CW'(1);
        wp_next = (wp_inc == row) ? '0 : AW'(wp_inc);
        fill_next = (fill_eff < row) ? fill_eff + CW'(1) : fill_eff;
        pend_next = (!action && pend_dec < row) ? pend_dec + CW'(1) : pend_dec;

        s1_valid_next = accept ? 1'b1 : (s1_take ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg.emit     <= emit;
            s1_item_reg.fend     <= fend;
            s1_item_reg.clr_left <= frame_start;
            s1_item_reg.below    <= pix;
        end
    end

    // right neighbor sits in the slot the pointer moves to next
    assign mem_we          = accept;
    assign mem_waddr       = wp_eff;
    assign mem_wdata       = pix;
    assign mem_raddr_cur   = wp_eff;
    assign mem_raddr_right = wp_next;

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

FILE: design/rsf_decide.sv
module rsf_decide (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [rsf_pkg::TH_W-1:0]   threshold,
    input  logic                       s1_valid,
    input  rsf_pkg::s1_item_t          s1_item,
    input  logic [rsf_pkg::PIX_W-1:0]  cur,
    input  logic [rsf_pkg::PIX_W-1:0]  right,
    output logic                       s1_take,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rsf_pkg::PIX_W-1:0]  filtered_value,
    output logic                       frame_end
);
    import rsf_pkg::*;

    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;
    logic [PIX_W-1:0] left_reg, left_next;

    logic [PIX_W-1:0] left_eff, v_a, v_b;
    logic             out_free;

    always_comb begin
        left_eff = s1_item.clr_left ? '0 : left_reg;

        v_a = (exceeds(cur, right, threshold) && exceeds(cur, s1_item.below, threshold))
              ? right : cur;
        v_b = (exceeds(right, v_a, threshold) && exceeds(left_eff, v_a, threshold))
              ? right : v_a;

        out_free = !m_valid_reg || m_tready;
        s1_take  = s1_valid && (!s1_item.emit || out_free);

        m_valid_next = m_valid_reg;
        if (s1_take && s1_item.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        left_next = left_reg;
        if (s1_take) begin
            left_next = s1_item.emit ? v_b : left_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            left_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_take && s1_item.emit) begin
            m_data_reg <= v_b;
            m_last_reg <= s1_item.fend;
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign filtered_value = m_data_reg;
    assign frame_end      = m_last_reg;

endmodule
